// File: design/ordered_list_table_engine_defines.svh
// ---------------------------------------------------------------------------
// ordered_list_table_engine_defines.svh
// Assertion macros used by the olte_core module of the ordered list table engine.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define OLTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define OLTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/olte_pkg.sv
// ---------------------------------------------------------------------------
// olte_pkg
// Field widths, command and status codes and word types of the list engine.
// ---------------------------------------------------------------------------
package olte_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int NAME_W = 64;
  localparam int TYPE_W = 2;
  localparam int ST_W   = 3;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  // Filter value that lists every type
  localparam logic [TYPE_W-1:0] TYPE_ANY = 2'd0;

  // One stored entry
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [TYPE_W-1:0] typ;
    logic              prio;
  } olte_entry_t;

  // One result word
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  index;
    logic [NAME_W-1:0] name;
    logic [TYPE_W-1:0] typ;
    logic              prio;
    logic [CNT_W-1:0]  count;
    logic              last;
  } olte_res_t;

endpackage

// File: design/ordered_list_table_engine.sv
// ---------------------------------------------------------------------------
// ordered_list_table_engine
// Ordered array list of up to DEPTH named entries with append, insert,
// delete, update, search by name and filtered listing.
// ---------------------------------------------------------------------------
//
//   channel  handshake             word
//   -------  --------------------  ----------------------------------------
//   in       in_valid / in_ready   cmd, position, name_key, type, priority
//   out      out_valid / out_ready status, index, name, type, priority,
//                                  entry_count, last
//
// Append, update and insert at the end pass decode, place and respond; rejects
// pass decode and respond; insert and delete also move one entry per step (up
// to DEPTH-1 moves); search and listing scan one entry per step (up to DEPTH).
// The entry memory has one write and one read port; that port sets the rate.
// Reset clears the control state and fill count; the memory needs no clearing pass.
// A stalled output freezes a listing scan when a new match meets a held word.
// ---------------------------------------------------------------------------
module ordered_list_table_engine #(
  parameter int DEPTH      = 32,
  parameter int NAME_CHARS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [olte_pkg::CMD_W-1:0]  in_cmd,
  input  logic [olte_pkg::POS_W-1:0]  in_position,
  input  logic [olte_pkg::NAME_W-1:0] in_name_key,
  input  logic [olte_pkg::TYPE_W-1:0] in_visit_type,
  input  logic                        in_priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [olte_pkg::ST_W-1:0]   out_status,
  output logic [olte_pkg::IDX_W-1:0]  out_index,
  output logic [olte_pkg::NAME_W-1:0] out_name,
  output logic [olte_pkg::TYPE_W-1:0] out_type,
  output logic                        out_priority,
  output logic [olte_pkg::CNT_W-1:0]  out_entry_count,
  output logic                        out_last
);
  import olte_pkg::*;

  logic      push_valid;
  logic      push_ready;
  olte_res_t push_res;
  logic      out_valid_r;
  olte_res_t out_res_r;

  olte_core #(
    .DEPTH      (DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_name_key     (in_name_key),
    .in_visit_type   (in_visit_type),
    .in_priority_req (in_priority_req),
    .push_ready      (push_ready),
    .push_valid      (push_valid),
    .push_res        (push_res)
  );

  // Take a new word when the output register is empty or being drained
  assign push_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_ready) begin
      out_valid_r <= push_valid;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      out_res_r <= push_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_index       = out_res_r.index;
  assign out_name        = out_res_r.name;
  assign out_type        = out_res_r.typ;
  assign out_priority    = out_res_r.prio;
  assign out_entry_count = out_res_r.count;
  assign out_last        = out_res_r.last;

endmodule

// File: design/olte_match.sv
// ---------------------------------------------------------------------------
// olte_match
// Shared compare unit: name match for search, type filter for listing.
// ---------------------------------------------------------------------------
module olte_match (
  input  logic                        is_search,
  input  olte_pkg::olte_entry_t       entry,
  input  logic [olte_pkg::NAME_W-1:0] key,
  input  logic [olte_pkg::TYPE_W-1:0] filt,
  output logic                        hit
);
  import olte_pkg::*;

  logic name_eq;
  logic type_ok;

  // Compare the full key and apply the type filter
  assign name_eq = (entry.name == key);
  assign type_ok = (filt == TYPE_ANY) || (entry.typ == filt);
  assign hit     = is_search ? name_eq : type_ok;

endmodule

// File: design/olte_core.sv
// ---------------------------------------------------------------------------
// olte_core
// Entry memory and the sequencer that walks it: shifts for insert and
// delete, scans for search and listing, one entry per cycle while no held listing word stalls.
// ---------------------------------------------------------------------------
`include "ordered_list_table_engine_defines.svh"

module olte_core #(
  parameter int DEPTH      = 32,
  parameter int NAME_CHARS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [olte_pkg::CMD_W-1:0]  in_cmd,
  input  logic [olte_pkg::POS_W-1:0]  in_position,
  input  logic [olte_pkg::NAME_W-1:0] in_name_key,
  input  logic [olte_pkg::TYPE_W-1:0] in_visit_type,
  input  logic                        in_priority_req,
  input  logic                        push_ready,
  output logic                        push_valid,
  output olte_pkg::olte_res_t         push_res
);
  import olte_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [NAME_W-1:0] NAME_MASK =
    (NAME_CHARS >= 8) ? {NAME_W{1'b1}} : ((64'd1 << (8 * NAME_CHARS)) - 64'd1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MOVE   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RESP   = 6'b100000
  } olte_state_t;

  olte_state_t state_r, state_nxt;

  // Latched command word
  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [NAME_W-1:0] key_r;
  logic [TYPE_W-1:0] vtyp_r;
  logic              prio_r;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] rank_r, rank_nxt;
  logic          pend_r, pend_nxt;

  // Result / pending listing word
  logic [ST_W-1:0]   rstat_r, rstat_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic [NAME_W-1:0] rname_r, rname_nxt;
  logic [TYPE_W-1:0] rtyp_r, rtyp_nxt;
  logic              rprio_r, rprio_nxt;

  // Memory and its ports
  olte_entry_t mem [DEPTH];
  olte_entry_t rdata_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  olte_entry_t wr_data;
  olte_entry_t new_entry;

  logic          hit;
  logic          full;
  logic          at_end;
  logic [XW-1:0] fill_x;
  logic [XW-1:0] pos_x;
  logic [CW-1:0] fill_m1;
  logic [AW-1:0] fill_a;
  logic [AW-1:0] fill_m1_a;
  logic [AW-1:0] pos_a;

  assign in_ready  = (state_r == S_IDLE);
  assign full      = (fill_r == CW'(DEPTH));
  assign fill_x    = XW'(fill_r);
  assign pos_x     = XW'(pos_r);
  assign fill_m1   = fill_r - CW'(1);
  assign fill_a    = AW'(fill_r);
  assign fill_m1_a = AW'(fill_m1);
  assign pos_a     = AW'(pos_r);
  assign at_end    = (cur_r == fill_m1_a);
  assign new_entry = '{name: key_r, typ: vtyp_r, prio: prio_r};

  olte_match u_match (
    .is_search (cmd_r == CMD_SEARCH),
    .entry     (rdata_r),
    .key       (key_r),
    .filt      (vtyp_r),
    .hit       (hit)
  );

  // Sequencer
  always_comb begin
    logic [AW-1:0] step_a;
    step_a     = cur_r;
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    cur_nxt    = cur_r;
    rank_nxt   = rank_r;
    pend_nxt   = pend_r;
    rstat_nxt  = rstat_r;
    ridx_nxt   = ridx_r;
    rname_nxt  = rname_r;
    rtyp_nxt   = rtyp_r;
    rprio_nxt  = rprio_r;
    rd_en      = 1'b0;
    rd_addr    = cur_r;
    wr_en      = 1'b0;
    wr_addr    = cur_r;
    wr_data    = rdata_r;
    push_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        rstat_nxt = ST_OK;
        ridx_nxt  = '0;
        rname_nxt = '0;
        rtyp_nxt  = '0;
        rprio_nxt = 1'b0;
        state_nxt = S_RESP;
        case (cmd_r)
          CMD_APPEND: begin
            if (full) begin
              rstat_nxt = ST_FULL;
            end else begin
              cur_nxt   = fill_a;
              state_nxt = S_PLACE;
            end
          end
          CMD_INSERT: begin
            if (full) begin
              rstat_nxt = ST_FULL;
            end else if (pos_x > fill_x) begin
              rstat_nxt = ST_BADPOS;
            end else if (pos_x == fill_x) begin
              cur_nxt   = fill_a;
              state_nxt = S_PLACE;
            end else begin
              cur_nxt   = fill_a;
              rd_en     = 1'b1;
              rd_addr   = fill_a - AW'(1);
              state_nxt = S_MOVE;
            end
          end
          CMD_DELETE: begin
            if (pos_x >= fill_x) begin
              rstat_nxt = ST_BADPOS;
            end else if (pos_x == fill_x - XW'(1)) begin
              fill_nxt = fill_m1;
              ridx_nxt = pos_a;
            end else begin
              cur_nxt   = pos_a;
              rd_en     = 1'b1;
              rd_addr   = pos_a + AW'(1);
              state_nxt = S_MOVE;
            end
          end
          CMD_UPDATE: begin
            if (pos_x >= fill_x) begin
              rstat_nxt = ST_BADPOS;
            end else begin
              cur_nxt   = pos_a;
              state_nxt = S_PLACE;
            end
          end
          CMD_SEARCH: begin
            if (fill_r == '0) begin
              rstat_nxt = ST_NOTFOUND;
            end else begin
              cur_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end
          CMD_LIST: begin
            if (fill_r == '0) begin
              rstat_nxt = ST_EMPTY;
            end else begin
              cur_nxt   = '0;
              rank_nxt  = '0;
              pend_nxt  = 1'b0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_MOVE: begin
        // Write the word read last cycle one place over, fetch the next one
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = rdata_r;
        if (cmd_r == CMD_INSERT) begin
          step_a = cur_r - AW'(1);
          if (step_a == pos_a) begin
            cur_nxt   = pos_a;
            state_nxt = S_PLACE;
          end else begin
            cur_nxt = step_a;
            rd_en   = 1'b1;
            rd_addr = step_a - AW'(1);
          end
        end else begin
          step_a = cur_r + AW'(1);
          if (step_a == fill_m1_a) begin
            fill_nxt  = fill_m1;
            ridx_nxt  = pos_a;
            state_nxt = S_RESP;
          end else begin
            cur_nxt = step_a;
            rd_en   = 1'b1;
            rd_addr = step_a + AW'(1);
          end
        end
      end
      S_PLACE: begin
        wr_en    = 1'b1;
        wr_addr  = cur_r;
        wr_data  = new_entry;
        ridx_nxt = cur_r;
        if (cmd_r != CMD_UPDATE) begin
          fill_nxt = fill_r + CW'(1);
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        step_a = cur_r + AW'(1);
        if (cmd_r == CMD_SEARCH) begin
          if (hit) begin
            ridx_nxt  = cur_r;
            rname_nxt = rdata_r.name;
            rtyp_nxt  = rdata_r.typ;
            rprio_nxt = rdata_r.prio;
            state_nxt = S_RESP;
          end else if (at_end) begin
            rstat_nxt = ST_NOTFOUND;
            state_nxt = S_RESP;
          end else begin
            cur_nxt = step_a;
            rd_en   = 1'b1;
            rd_addr = step_a;
          end
        end else if (!(hit && pend_r && !push_ready)) begin
          // Release the held word, hold the new match until the next one shows
          if (hit) begin
            push_valid = pend_r;
            ridx_nxt   = rank_r;
            rname_nxt  = rdata_r.name;
            rtyp_nxt   = rdata_r.typ;
            rprio_nxt  = rdata_r.prio;
            rank_nxt   = rank_r + AW'(1);
            pend_nxt   = 1'b1;
          end
          if (at_end) begin
            if (!(pend_r || hit)) begin
              rstat_nxt = ST_EMPTY;
            end
            state_nxt = S_RESP;
          end else begin
            cur_nxt = step_a;
            rd_en   = 1'b1;
            rd_addr = step_a;
          end
        end
      end
      S_RESP: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result word toward the output register
  always_comb begin
    push_res.status = rstat_r;
    push_res.index  = IDX_W'(ridx_r);
    push_res.name   = rname_r;
    push_res.typ    = rtyp_r;
    push_res.prio   = rprio_r;
    push_res.count  = CNT_W'(fill_r);
    push_res.last   = (state_r == S_RESP);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      pos_r  <= in_position;
      key_r  <= in_name_key & NAME_MASK;
      vtyp_r <= in_visit_type;
      prio_r <= in_priority_req;
    end
    cur_r   <= cur_nxt;
    rank_r  <= rank_nxt;
    rstat_r <= rstat_nxt;
    ridx_r  <= ridx_nxt;
    rname_r <= rname_nxt;
    rtyp_r  <= rtyp_nxt;
    rprio_r <= rprio_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  `OLTE_ASSERT_IMP(a_mid_push_is_list, push_valid && (state_r != S_RESP), cmd_r == CMD_LIST && pend_r, "word released mid-scan outside a listing")
  `OLTE_ASSERT_IMP(a_ports_apart, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same entry")
  `OLTE_ASSERT_IMP(a_read_live, rd_en, CW'(rd_addr) < fill_r, "read of an entry beyond the fill count")
  `OLTE_ASSERT_NXT(a_fill_steady, state_r == S_IDLE || state_r == S_SCAN || state_r == S_RESP, $stable(fill_r), "fill count moved outside decode, move or place")

endmodule
